// File: sv/modulated_fractional_delay_line_assert.svh
// Assertion macros shared by the delay line RTL.
`ifndef MODULATED_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`define MODULATED_FRACTIONAL_DELAY_LINE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: sv/mfdl_pkg.sv
// Package with widths, constants, register indexes and helpers for the delay line.
package mfdl_pkg;

	localparam int DEPTH_DEF = 131072;

	localparam int AUDIO_W    = 24;
	localparam int MOD_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 21;

	localparam int DLYUS_W = 21;
	localparam int FB_W    = 16;
	localparam int WET_W   = 17;
	localparam int COEF_W  = 16;
	localparam int SR_W    = 18;

	// Smoothed delay time in 2^-16 microsecond units, and the width of its target.
	localparam int SMOOTH_W = 38;
	localparam int TARGET_W = 37;

	// Product of smoothed time and sample rate, divided down to samples.
	localparam int PROD_W        = SMOOTH_W + SR_W;
	localparam int DIV_STEP_BITS = 8;
	localparam int DIV_STEPS     = PROD_W / DIV_STEP_BITS;
	localparam int DIV_REM_W     = 20;
	localparam logic [DIV_REM_W-1:0] US_PER_S = 20'd1000000;

	localparam logic [FB_W-1:0]         FB_MAX_Q16  = 16'd64225;
	localparam logic signed [37:0]      CHORUS_BASE = 38'sd196608000;
	localparam logic signed [13:0]      CHORUS_SPAN = 14'sd4000;
	localparam logic [WET_W-1:0]        UNITY_Q16   = 17'd65536;

	localparam int ACC_W = 44;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE        = 3'd0,
		CFG_DELAY_US    = 3'd1,
		CFG_FEEDBACK    = 3'd2,
		CFG_WET_MIX     = 3'd3,
		CFG_SMOOTH_COEF = 3'd4,
		CFG_SAMPLE_RATE = 3'd5
	} cfg_idx_t;

	// Saturates a wide signed value onto the signed 24-bit audio range.
	function automatic logic signed [AUDIO_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(24'sh7FFFFF);
		lo = -ACC_W'(signed'(25'sh0800000));
		if (v > hi) begin
			sat24 = 24'sh7FFFFF;
		end else if (v < lo) begin
			sat24 = 24'sh800000;
		end else begin
			sat24 = v[AUDIO_W-1:0];
		end
	endfunction

endpackage

// File: sv/mfdl_if.sv
// Valid/ready channel interfaces for samples in, samples out and register writes.
interface mfdl_in_if;
	import mfdl_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [AUDIO_W-1:0] audio_in;
	logic signed [MOD_W-1:0]   modulation;
	logic                      block_end;
	modport source (output valid, output audio_in, output modulation, output block_end,
		input ready);
	modport sink (input valid, input audio_in, input modulation, input block_end,
		output ready);
endinterface

interface mfdl_out_if;
	import mfdl_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [AUDIO_W-1:0] audio_out;
	logic                      block_end_out;
	modport source (output valid, output audio_out, output block_end_out, input ready);
	modport sink (input valid, input audio_out, input block_end_out, output ready);
endinterface

interface mfdl_cfg_if;
	import mfdl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/mfdl_div.sv
// Radix-256 restoring divider that turns time-by-rate products into delay samples.
module mfdl_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mfdl_pkg::PROD_W-1:0]  dividend,
	output logic                         done,
	output logic [mfdl_pkg::PROD_W-1:0]  quotient
);
	import mfdl_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PROD_W-1:0]    sh_q;
	logic [PROD_W-1:0]    sh_nxt;
	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_REM_W-1:0] rem_nxt;
	logic [DIV_REM_W:0]   r_w;

	// Eight quotient bits per cycle; dividend bits leave at the top of the shift
	// register while quotient bits enter at the bottom.
	always_comb begin
		r_w    = {1'b0, rem_q};
		sh_nxt = sh_q;
		for (int k = 0; k < DIV_STEP_BITS; k++) begin
			r_w    = {r_w[DIV_REM_W-1:0], sh_nxt[PROD_W-1]};
			sh_nxt = {sh_nxt[PROD_W-2:0], 1'b0};
			if (r_w >= {1'b0, US_PER_S}) begin
				r_w       = r_w - {1'b0, US_PER_S};
				sh_nxt[0] = 1'b1;
			end
		end
		rem_nxt = r_w[DIV_REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q  <= sh_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// File: sv/modulated_fractional_delay_line.sv
// Top level of the modulated fractional delay line (feedback delay and chorus).
//
//   channel   role   handshake         word
//   din       sink   valid / ready     audio_in, modulation, block_end
//   dout      source valid / ready     audio_out, block_end_out
//   cfg       sink   valid / ready     index, data (register write)
//
// Each sample is carried from one accepted word to the next by a sequencer around
// the ring memory, which has one write and one read port; its product of smoothed
// time and sample rate is divided down to samples in the radix-256 divider.
// After reset the ring is swept to zero, one entry per cycle, through all DEPTH
// entries (131072 at the default depth); no sample is taken meanwhile, register writes are.
// A result waiting in the output register does not block the next input word;
// the sequencer only waits in its final step if the previous result is still held.
`include "modulated_fractional_delay_line_assert.svh"

module modulated_fractional_delay_line #(
	parameter int DEPTH = mfdl_pkg::DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mfdl_in_if.sink     din,
	mfdl_out_if.source  dout,
	mfdl_cfg_if.sink    cfg
);
	import mfdl_pkg::*;

	// Ring addresses, and the delay in samples with sixteen fractional bits.
	localparam int AW = $clog2(DEPTH);
	localparam int DW = AW + 16;
	localparam logic [AW-1:0]     LAST = AW'(DEPTH - 1);
	localparam logic [PROD_W-1:0] LIM  = PROD_W'(DEPTH - 2) << 16;
	localparam logic [DW:0]       WRAP = (DW + 1)'(DEPTH) << 16;

	// The sequencer walks one sample through these steps in order.
	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TGT,
		ST_MAG,
		ST_MLO,
		ST_MHI,
		ST_STEP,
		ST_SMOOTH,
		ST_PLO,
		ST_PHI,
		ST_PSUM,
		ST_DIV,
		ST_CLAMP,
		ST_POS,
		ST_IDX,
		ST_RD1,
		ST_RD0,
		ST_INTERP,
		ST_WRITE,
		ST_MIX,
		ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic               mode_q;
	logic [DLYUS_W-1:0] delay_us_q;
	logic [FB_W-1:0]    fb_q;
	logic [WET_W-1:0]   wet_q;
	logic [COEF_W-1:0]  coef_q;
	logic [SR_W-1:0]    srate_q;

	// State that lives across samples.
	logic [AW-1:0]              clr_q;
	logic [AW-1:0]              wp_q;
	logic [SMOOTH_W-1:0]        s_q;
	logic signed [AUDIO_W-1:0]  last_read_q;
	logic                       out_valid_q;
	logic signed [AUDIO_W-1:0]  audio_out_q;
	logic                       bend_out_q;

	// Per-sample working registers.
	logic signed [AUDIO_W-1:0]  x_q;
	logic signed [MOD_W-1:0]    mod_q;
	logic                       bend_q;
	logic [TARGET_W-1:0]        target_q;
	logic [FB_W-1:0]            fbm_q;
	logic signed [41:0]         mixa_q;
	logic                       neg_q;
	logic [SMOOTH_W-1:0]        mag_q;
	logic [34:0]                plo_q;
	logic [34:0]                phi_q;
	logic [SMOOTH_W-1:0]        step_q;
	logic [36:0]                qlo_q;
	logic [36:0]                qhi_q;
	logic [DW-1:0]              dly_q;
	logic [DW:0]                pdiff_q;
	logic [AW-1:0]              ip_q;
	logic [15:0]                fr_q;
	logic [AW-1:0]              i0_q;
	logic signed [AUDIO_W-1:0]  y1_q;
	logic signed [AUDIO_W-1:0]  y0_q;
	logic signed [41:0]         iprod_q;
	logic signed [40:0]         fbprod_q;
	logic signed [AUDIO_W-1:0]  rd_q;
	logic signed [41:0]         mixb_q;

	// Ring memory and its ports.
	logic signed [AUDIO_W-1:0]  ring_mem [0:DEPTH-1];
	logic signed [AUDIO_W-1:0]  mem_rdata_q;
	logic                       mem_we;
	logic                       mem_re;
	logic [AW-1:0]              mem_waddr;
	logic [AW-1:0]              mem_raddr;
	logic signed [AUDIO_W-1:0]  mem_wdata;

	// Combinational helpers.
	logic [WET_W-1:0]           wet_lim_w;
	logic [WET_W-1:0]           dry_w;
	logic signed [29:0]         span_w;
	logic signed [37:0]         chorus_w;
	logic [TARGET_W-1:0]        target_w;
	logic [31:0]                fb_prod_w;
	logic [SMOOTH_W:0]          d_up_w;
	logic [SMOOTH_W:0]          d_dn_w;
	logic [53:0]                step_sum_w;
	logic [PROD_W-1:0]          dividend_w;
	logic                       div_start;
	logic                       div_done;
	logic [PROD_W-1:0]          div_q;
	logic [DW:0]                pdiff_w;
	logic [DW:0]                pos_w;
	logic [AW-1:0]              i0_w;
	logic signed [AUDIO_W:0]    idiff_w;
	logic signed [ACC_W-1:0]    rd_full_w;
	logic signed [AUDIO_W-1:0]  rd_w;
	logic signed [AUDIO_W-1:0]  store_w;
	logic signed [ACC_W-1:0]    mix_sum_w;
	logic signed [AUDIO_W-1:0]  mix_w;

	// A wet share above one is held at one; the dry share is what remains.
	assign wet_lim_w = (wet_q > UNITY_Q16) ? UNITY_Q16 : wet_q;
	assign dry_w     = UNITY_Q16 - wet_lim_w;

	// The chorus target is 3 ms plus 2 ms times the modulation, in 2^-16 us.
	assign span_w    = 30'(mod_q) * 30'(CHORUS_SPAN);
	assign chorus_w  = CHORUS_BASE + 38'(span_w);
	assign target_w  = mode_q ? chorus_w[TARGET_W-1:0] : {delay_us_q, 16'd0};

	// Feedback knob mapped onto 0 to 0.98.
	assign fb_prod_w = 32'(fb_q) * 32'(FB_MAX_Q16);

	// Both differences are formed at once; the sign of the first picks the magnitude.
	assign d_up_w = {2'b00, target_q} - {1'b0, s_q};
	assign d_dn_w = {1'b0, s_q} - {2'b00, target_q};

	// The smoothing step is the coefficient times the distance, from two halves.
	assign step_sum_w = {phi_q, 19'd0} + 54'(plo_q);

	// Smoothed time times sample rate, again from two halves of the time.
	assign dividend_w = {qhi_q, 19'd0} + PROD_W'(qlo_q);
	assign div_start  = (state_q == ST_PSUM);

	mfdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend_w),
		.done     (div_done),
		.quotient (div_q)
	);

	// The read point trails the write pointer by the delay, wrapping round the ring.
	assign pdiff_w = {1'b0, wp_q, 16'd0} - {1'b0, dly_q};
	assign pos_w   = pdiff_q[DW] ? (pdiff_q + WRAP) : pdiff_q;
	assign i0_w    = (ip_q == '0) ? LAST : (ip_q - AW'(1));

	// Linear interpolation from the older entry towards the newer one; the
	// arithmetic shift rounds towards minus infinity.
	assign idiff_w   = (AUDIO_W + 1)'(y1_q) - (AUDIO_W + 1)'(mem_rdata_q);
	assign rd_full_w = ACC_W'(y0_q) + ACC_W'(iprod_q >>> 16);
	assign rd_w      = rd_full_w[AUDIO_W-1:0];

	// The ring takes the input plus the previous read times the feedback gain.
	assign store_w = sat24(ACC_W'(x_q) + ACC_W'(fbprod_q >>> 16));

	// Dry/wet mix of input and delayed read.
	assign mix_sum_w = (ACC_W'(mixa_q) + ACC_W'(mixb_q)) >>> 16;
	assign mix_w     = sat24(mix_sum_w);

	// Ring memory: the clearing sweep and the per-sample store share the write
	// port; the two interpolation taps are read in consecutive cycles. Reads and
	// the store of one sample fall in separate steps, so nothing overlaps.
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : wp_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : store_w;
	assign mem_re    = (state_q == ST_RD1) || (state_q == ST_RD0);
	assign mem_raddr = (state_q == ST_RD1) ? ip_q : i0_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= ring_mem[mem_raddr];
		end
	end

	// Register writes are always taken; indexes beyond the list are dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			delay_us_q <= '0;
			fb_q       <= '0;
			wet_q      <= 17'd32768;
			coef_q     <= 16'd7;
			srate_q    <= 18'd48000;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MODE:        mode_q     <= cfg.data[0];
				CFG_DELAY_US:    delay_us_q <= cfg.data[DLYUS_W-1:0];
				CFG_FEEDBACK:    fb_q       <= cfg.data[FB_W-1:0];
				CFG_WET_MIX:     wet_q      <= cfg.data[WET_W-1:0];
				CFG_SMOOTH_COEF: coef_q     <= cfg.data[COEF_W-1:0];
				CFG_SAMPLE_RATE: srate_q    <= cfg.data[SR_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: state, the values kept between samples and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			wp_q        <= '0;
			s_q         <= '0;
			last_read_q <= '0;
			out_valid_q <= 1'b0;
			audio_out_q <= '0;
			bend_out_q  <= 1'b0;
		end else begin
			if (out_valid_q && dout.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (din.valid) begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT:    state_q <= ST_MAG;
				ST_MAG:    state_q <= ST_MLO;
				ST_MLO:    state_q <= ST_MHI;
				ST_MHI:    state_q <= ST_STEP;
				ST_STEP:   state_q <= ST_SMOOTH;
				ST_SMOOTH: begin
					s_q     <= neg_q ? (s_q - step_q) : (s_q + step_q);
					state_q <= ST_PLO;
				end
				ST_PLO:    state_q <= ST_PHI;
				ST_PHI:    state_q <= ST_PSUM;
				ST_PSUM:   state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP:  state_q <= ST_POS;
				ST_POS:    state_q <= ST_IDX;
				ST_IDX:    state_q <= ST_RD1;
				ST_RD1:    state_q <= ST_RD0;
				ST_RD0:    state_q <= ST_INTERP;
				ST_INTERP: state_q <= ST_WRITE;
				ST_WRITE: begin
					last_read_q <= rd_w;
					wp_q        <= (wp_q == LAST) ? '0 : (wp_q + AW'(1));
					state_q     <= ST_MIX;
				end
				ST_MIX:    state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_valid_q || dout.ready) begin
						out_valid_q <= 1'b1;
						audio_out_q <= mix_w;
						bend_out_q  <= bend_q;
						state_q     <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers, each loaded in the step that produces it.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (din.valid) begin
					x_q    <= din.audio_in;
					mod_q  <= din.modulation;
					bend_q <= din.block_end;
				end
			end
			ST_TGT: begin
				target_q <= target_w;
				fbm_q    <= fb_prod_w[31:16];
				mixa_q   <= 42'(x_q) * 42'($signed({1'b0, dry_w}));
			end
			ST_MAG: begin
				neg_q <= d_up_w[SMOOTH_W];
				mag_q <= d_up_w[SMOOTH_W] ? d_dn_w[SMOOTH_W-1:0] : d_up_w[SMOOTH_W-1:0];
			end
			ST_MLO:  plo_q  <= 35'(coef_q) * 35'(mag_q[18:0]);
			ST_MHI:  phi_q  <= 35'(coef_q) * 35'(mag_q[SMOOTH_W-1:19]);
			ST_STEP: step_q <= step_sum_w[53:16];
			ST_PLO:  qlo_q  <= 37'(s_q[18:0]) * 37'(srate_q);
			ST_PHI:  qhi_q  <= 37'(s_q[SMOOTH_W-1:19]) * 37'(srate_q);
			ST_CLAMP: dly_q <= (div_q > LIM) ? LIM[DW-1:0] : div_q[DW-1:0];
			ST_POS:  pdiff_q <= pdiff_w;
			ST_IDX: begin
				ip_q <= pos_w[DW-1:16];
				fr_q <= pos_w[15:0];
			end
			ST_RD1:  i0_q <= i0_w;
			ST_RD0:  y1_q <= mem_rdata_q;
			ST_INTERP: begin
				y0_q     <= mem_rdata_q;
				iprod_q  <= 42'(idiff_w) * 42'($signed({1'b0, fr_q}));
				fbprod_q <= 41'(last_read_q) * 41'($signed({1'b0, fbm_q}));
			end
			ST_WRITE: rd_q   <= rd_w;
			ST_MIX:   mixb_q <= 42'(rd_q) * 42'($signed({1'b0, wet_lim_w}));
			default: ;
		endcase
	end

	assign din.ready          = (state_q == ST_IDLE);
	assign dout.valid         = out_valid_q;
	assign dout.audio_out     = audio_out_q;
	assign dout.block_end_out = bend_out_q;

	// The write pointer never leaves the ring.
	`ASSERT_IMPLIES(a_wp_in_ring, clk, arst_n, 1'b1, wp_q <= LAST)
	// The smoother never overshoots its target, which stays below 2^37.
	`ASSERT_IMPLIES(a_smooth_bound, clk, arst_n, 1'b1, s_q[SMOOTH_W-1] == 1'b0)
	// A divider result only arrives while the sequencer waits for it.
	`ASSERT_IMPLIES(a_div_done_waited, clk, arst_n, div_done, state_q == ST_DIV)
	// A new result only appears from the final step.
	`ASSERT_IMPLIES(a_result_source, clk, arst_n, $rose(out_valid_q), $past(state_q) == ST_OUT)
	// Once the interpolation taps are fetched, the sample is stored next.
	`ASSERT_NEXT(a_store_follows, clk, arst_n, state_q == ST_INTERP, mem_we && mem_waddr == wp_q)

endmodule
